>>> src/svpd_pkg.sv
package svpd_pkg;

  localparam int DUTY_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;

  // sqrt(3) in Q2.30.
  localparam longint SQRT3_Q30 = 64'sd1859775393;

  localparam logic [2:0] SEC_NONE = 3'd0;
  localparam logic [2:0] SEC_1    = 3'd1;
  localparam logic [2:0] SEC_2    = 3'd2;
  localparam logic [2:0] SEC_3    = 3'd3;
  localparam logic [2:0] SEC_4    = 3'd4;
  localparam logic [2:0] SEC_5    = 3'd5;
  localparam logic [2:0] SEC_6    = 3'd6;

  // Status of the queue between the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Rounded sqrt(3) with ab fraction bits.
  function automatic longint sqrt3_k(input int ab);
    longint r;
    r = (SQRT3_Q30 + (longint'(1) << (29 - ab))) >>> (30 - ab);
    return r;
  endfunction

endpackage

>>> src/space_vector_pwm_duties.sv
// Space vector PWM duty generator, seven-segment and center-aligned.
// Input channel (in_valid / in_stall): one item carries the alpha and beta
// voltages and the DC bus voltage. Result channel (out_valid / out_stall):
// one item per input with the sector, three phase duties, three phase
// voltages and a saturation flag.
// A three-stage front finds the sector and the doubled phase times exactly
// as integers; a four-entry queue parts it from the back, where three
// pipelined restoring dividers (one quotient bit per stage) and a multiplier
// form each duty and phase voltage.
// Throughput is one item per cycle when nothing stalls, set by the
// one-bit-per-stage divider pipeline.
// When the receiver stalls, the back pipeline holds its results and the
// queue fills; the front then raises in_stall once an item waits at its end.
// Synchronous active-low reset empties all stages and the queue; no item is
// shown until a new one is accepted.
module space_vector_pwm_duties #(
  parameter int DUTY_BITS  = svpd_pkg::DUTY_BITS_DEF,
  parameter int ANGLE_BITS = svpd_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_voltage_alpha,
  input  logic signed [15:0] in_voltage_beta,
  input  logic        [15:0] in_bus_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_sector,
  output logic [15:0]        out_duty_a,
  output logic [15:0]        out_duty_b,
  output logic [15:0]        out_duty_c,
  output logic [15:0]        out_phase_volt_a,
  output logic [15:0]        out_phase_volt_b,
  output logic [15:0]        out_phase_volt_c,
  output logic               out_saturated
);
  import svpd_pkg::*;

  // Signed width of the scaled times, with headroom for the sums of the front.
  localparam int TW = ANGLE_BITS + 22;
  // Queue entry: sector, bus voltage and three doubled phase times.
  localparam int FW = 3 * TW + 19;

  q_stat_t       q_stat;
  logic          push, pop;
  logic [FW-1:0] push_data, pop_data;

  svpd_front #(.ANGLE_BITS(ANGLE_BITS), .TW(TW), .FW(FW)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_alpha(in_voltage_alpha), .in_beta(in_voltage_beta), .in_bus(in_bus_voltage),
    .q_stat(q_stat), .push(push), .push_data(push_data));

  svpd_fifo #(.FW(FW)) u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .push_data(push_data),
    .pop(pop), .pop_data(pop_data), .q_stat(q_stat));

  svpd_back #(.DUTY_BITS(DUTY_BITS), .ANGLE_BITS(ANGLE_BITS), .TW(TW), .FW(FW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_stat(q_stat), .pop_data(pop_data), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_sector(out_sector),
    .out_duty_a(out_duty_a), .out_duty_b(out_duty_b), .out_duty_c(out_duty_c),
    .out_phase_volt_a(out_phase_volt_a), .out_phase_volt_b(out_phase_volt_b),
    .out_phase_volt_c(out_phase_volt_c), .out_saturated(out_saturated));

endmodule

>>> src/svpd_front.sv
module svpd_front #(
  parameter int ANGLE_BITS = 16,
  parameter int TW = ANGLE_BITS + 22,
  parameter int FW = 3 * TW + 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_alpha,
  input  logic signed [15:0] in_beta,
  input  logic        [15:0] in_bus,
  input  svpd_pkg::q_stat_t  q_stat,
  output logic               push,
  output logic [FW-1:0]      push_data
);
  import svpd_pkg::*;

  localparam logic signed [ANGLE_BITS+2:0] KS = (ANGLE_BITS + 3)'(sqrt3_k(ANGLE_BITS));

  logic en;
  logic v1_r, v2_r, v3_r;

  // Stage 1: products.
  logic signed [15:0]   a1_r, b1_r;
  logic        [15:0]   bus1_r;
  logic signed [TW-1:0] kb1_r;
  logic signed [33:0]   aa1_r, bb1_r;
  logic signed [TW-1:0] kb_c;
  logic signed [33:0]   aa_c, bb_c;

  assign kb_c = TW'(KS) * TW'(in_beta);
  assign aa_c = 34'(in_alpha) * 34'(in_alpha);
  assign bb_c = 34'(in_beta) * 34'(in_beta);

  // Stage 2: sector and the x, y, z terms.
  logic        [2:0]    sec2_r;
  logic signed [TW-1:0] x2_r, y2_r, z2_r, n2_r;
  logic        [15:0]   bus2_r;
  logic        [2:0]    sec_c;
  logic                 steep, upper;
  logic signed [33:0]   aa3;
  logic signed [TW-1:0] ax, a3s, n_c;

  assign aa3   = aa1_r + (aa1_r <<< 1);
  assign steep = bb1_r > aa3;
  assign upper = (b1_r > 0) || (b1_r == 0 && a1_r > 0);
  assign ax    = TW'(a1_r);
  assign a3s   = (ax + (ax <<< 1)) <<< ANGLE_BITS;
  assign n_c   = $signed({{(TW - ANGLE_BITS - 17){1'b0}}, bus1_r, {(ANGLE_BITS + 1){1'b0}}});

  always_comb begin
    if (bus1_r == 16'd0) begin
      sec_c = SEC_NONE;
    end else if (a1_r == 16'sd0) begin
      sec_c = SEC_2;
    end else if (upper) begin
      sec_c = steep ? SEC_2 : ((a1_r > 0) ? SEC_1 : SEC_3);
    end else begin
      sec_c = steep ? SEC_5 : ((a1_r < 0) ? SEC_4 : SEC_6);
    end
  end

  // Stage 3: active times and the doubled phase times.
  logic        [2:0]    sec3_r;
  logic        [15:0]   bus3_r;
  logic signed [TW-1:0] ta3_r, tb3_r, tc3_r;
  logic signed [TW-1:0] t1, t2, p, m, u, w;
  logic signed [TW-1:0] ta_c, tb_c, tc_c;

  always_comb begin
    unique case (sec2_r)
      SEC_1:   begin t1 = -z2_r; t2 = x2_r;  end
      SEC_2:   begin t1 = y2_r;  t2 = z2_r;  end
      SEC_3:   begin t1 = x2_r;  t2 = -y2_r; end
      SEC_4:   begin t1 = z2_r;  t2 = -x2_r; end
      SEC_5:   begin t1 = -y2_r; t2 = -z2_r; end
      default: begin t1 = -x2_r; t2 = y2_r;  end
    endcase
    p = n2_r + t1 + t2;
    m = n2_r - t1 - t2;
    u = n2_r + t1 - t2;
    w = n2_r - t1 + t2;
    unique case (sec2_r)
      SEC_1:   begin ta_c = p; tb_c = w; tc_c = m; end
      SEC_2:   begin ta_c = u; tb_c = p; tc_c = m; end
      SEC_3:   begin ta_c = m; tb_c = p; tc_c = w; end
      SEC_4:   begin ta_c = m; tb_c = u; tc_c = p; end
      SEC_5:   begin ta_c = w; tb_c = m; tc_c = p; end
      default: begin ta_c = p; tb_c = m; tc_c = u; end
    endcase
  end

  assign en        = !(v3_r && q_stat.full);
  assign in_stall  = !en;
  assign push      = v3_r && !q_stat.full;
  assign push_data = {sec3_r, bus3_r, ta3_r, tb3_r, tc3_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= in_alpha;
      b1_r   <= in_beta;
      bus1_r <= in_bus;
      kb1_r  <= kb_c;
      aa1_r  <= aa_c;
      bb1_r  <= bb_c;
      sec2_r <= sec_c;
      bus2_r <= bus1_r;
      n2_r   <= n_c;
      x2_r   <= kb1_r <<< 1;
      y2_r   <= a3s + kb1_r;
      z2_r   <= kb1_r - a3s;
      sec3_r <= sec2_r;
      bus3_r <= bus2_r;
      ta3_r  <= ta_c;
      tb3_r  <= tb_c;
      tc3_r  <= tc_c;
    end
  end

endmodule

>>> src/svpd_fifo.sv
module svpd_fifo #(
  parameter int FW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [FW-1:0]     push_data,
  input  logic              pop,
  output logic [FW-1:0]     pop_data,
  output svpd_pkg::q_stat_t q_stat
);
  import svpd_pkg::*;

  localparam int DEPTH = 4;
  localparam int AW = $clog2(DEPTH);

  logic [FW-1:0] mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic          do_pop;

  assign q_stat.full  = (cnt_r == (AW + 1)'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_pop       = pop && !q_stat.empty;
  assign pop_data     = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (AW + 1)'(push) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_data;
  end

endmodule

>>> src/svpd_lane.sv
module svpd_lane #(
  parameter int DUTY_BITS  = 16,
  parameter int ANGLE_BITS = 16,
  parameter int TW = ANGLE_BITS + 22
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [TW-1:0] t_in,
  input  logic        [15:0]   bus_in,
  output logic        [15:0]   duty,
  output logic        [15:0]   volt,
  output logic                 sat
);
  localparam int DW = ANGLE_BITS + 18;
  localparam int RW = DW + 1;
  localparam int QW = DUTY_BITS + 2;
  localparam int NS = DUTY_BITS + 2;
  localparam logic [DUTY_BITS-1:0] FULL = '1;

  logic [RW-1:0]    rem_r [NS];
  logic [QW-1:0]    q_r   [NS];
  logic [15:0]      bus_r [NS];
  logic             sat_r [NS];

  // Entry stage: clamp to 0..1 and take the integer quotient bit.
  logic [DW-1:0] den0, num0;
  logic          sat0, q0;

  assign den0 = {bus_in, {(ANGLE_BITS + 2){1'b0}}};

  always_comb begin
    if (t_in < 0) begin
      num0 = '0;
      sat0 = 1'b1;
    end else if (t_in > $signed({{(TW - DW){1'b0}}, den0})) begin
      num0 = den0;
      sat0 = 1'b1;
    end else begin
      num0 = t_in[DW-1:0];
      sat0 = 1'b0;
    end
    q0 = (num0 == den0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= q0 ? '0 : {1'b0, num0};
      q_r[0]   <= QW'(q0);
      bus_r[0] <= bus_in;
      sat_r[0] <= sat0;
    end
  end

  // One restoring quotient bit per stage.
  for (genvar j = 0; j < NS - 1; j++) begin : g_div
    logic [RW-1:0] r2, dn;
    assign r2 = {rem_r[j][RW-2:0], 1'b0};
    assign dn = {1'b0, bus_r[j], {(ANGLE_BITS + 2){1'b0}}};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1] <= (r2 >= dn) ? r2 - dn : r2;
        q_r[j+1]   <= {q_r[j][QW-2:0], (r2 >= dn)};
        bus_r[j+1] <= bus_r[j];
        sat_r[j+1] <= sat_r[j];
      end
    end
  end

  // Round half up, clamp full scale, then scale by the bus voltage.
  logic [QW:0]                 qp;
  logic [QW-1:0]               dr;
  logic [DUTY_BITS-1:0]        d_r, d2_r, d3_r;
  logic [15:0]                 busd_r;
  logic                        sd_r, s2_r, s3_r;
  logic [DUTY_BITS+15:0]       prod_r, prod_rnd;
  logic [15:0]                 volt_r;
  logic [DUTY_BITS+15:0]       dx;

  assign qp       = {1'b0, q_r[NS-1]} + 1'b1;
  assign dr       = qp[QW:1];
  assign prod_rnd = prod_r + (DUTY_BITS + 16)'(1 << (DUTY_BITS - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= (dr > QW'(FULL)) ? FULL : dr[DUTY_BITS-1:0];
      busd_r <= bus_r[NS-1];
      sd_r   <= sat_r[NS-1];
      prod_r <= d_r * busd_r;
      d2_r   <= d_r;
      s2_r   <= sd_r;
      volt_r <= prod_rnd[DUTY_BITS+15:DUTY_BITS];
      d3_r   <= d2_r;
      s3_r   <= s2_r;
    end
  end

  assign dx   = {16'd0, d3_r};
  assign duty = dx[15:0];
  assign volt = volt_r;
  assign sat  = s3_r;

endmodule

>>> src/svpd_back.sv
module svpd_back #(
  parameter int DUTY_BITS  = 16,
  parameter int ANGLE_BITS = 16,
  parameter int TW = ANGLE_BITS + 22,
  parameter int FW = 3 * TW + 19
) (
  input  logic              clk,
  input  logic              rst_n,
  input  svpd_pkg::q_stat_t q_stat,
  input  logic [FW-1:0]     pop_data,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_sector,
  output logic [15:0]       out_duty_a,
  output logic [15:0]       out_duty_b,
  output logic [15:0]       out_duty_c,
  output logic [15:0]       out_phase_volt_a,
  output logic [15:0]       out_phase_volt_b,
  output logic [15:0]       out_phase_volt_c,
  output logic              out_saturated
);
  import svpd_pkg::*;

  // Lane pipeline: entry stage, DUTY_BITS+1 quotient stages, round, multiply, scale.
  localparam int LAT = DUTY_BITS + 5;

  logic en;
  logic v_r [LAT];
  logic [2:0] sec_r [LAT];

  logic [2:0]           sec_in;
  logic [15:0]          bus_in;
  logic signed [TW-1:0] ta, tb, tc;
  logic [15:0] da, db, dc, va, vb, vc;
  logic        sa, sb, sc, zero;

  assign {sec_in, bus_in, ta, tb, tc} = pop_data;
  assign en  = !v_r[LAT-1] || !out_stall;
  assign pop = en && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= !q_stat.empty;
      for (int i = 1; i < LAT; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sec_r[0] <= sec_in;
      for (int i = 1; i < LAT; i++) sec_r[i] <= sec_r[i-1];
    end
  end

  svpd_lane #(.DUTY_BITS(DUTY_BITS), .ANGLE_BITS(ANGLE_BITS), .TW(TW)) u_lane_a (
    .clk(clk), .en(en), .t_in(ta), .bus_in(bus_in), .duty(da), .volt(va), .sat(sa));
  svpd_lane #(.DUTY_BITS(DUTY_BITS), .ANGLE_BITS(ANGLE_BITS), .TW(TW)) u_lane_b (
    .clk(clk), .en(en), .t_in(tb), .bus_in(bus_in), .duty(db), .volt(vb), .sat(sb));
  svpd_lane #(.DUTY_BITS(DUTY_BITS), .ANGLE_BITS(ANGLE_BITS), .TW(TW)) u_lane_c (
    .clk(clk), .en(en), .t_in(tc), .bus_in(bus_in), .duty(dc), .volt(vc), .sat(sc));

  // A zero bus voltage shows up as the invalid sector; its lane results are masked.
  assign zero             = (sec_r[LAT-1] == SEC_NONE);
  assign out_valid        = v_r[LAT-1];
  assign out_sector       = sec_r[LAT-1];
  assign out_duty_a       = zero ? 16'd0 : da;
  assign out_duty_b       = zero ? 16'd0 : db;
  assign out_duty_c       = zero ? 16'd0 : dc;
  assign out_phase_volt_a = zero ? 16'd0 : va;
  assign out_phase_volt_b = zero ? 16'd0 : vb;
  assign out_phase_volt_c = zero ? 16'd0 : vc;
  assign out_saturated    = !zero && (sa || sb || sc);

endmodule

>>> src/svpd_checker.sv
module svpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_sector,
  input logic [15:0] out_duty_a,
  input logic [15:0] out_duty_b,
  input logic [15:0] out_duty_c,
  input logic        out_saturated
);
  import svpd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_a) && $stable(out_sector))
    else $error("stalled result changed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_sector: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_sector <= SEC_6)
    else $error("sector out of range");

  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sector == SEC_NONE |->
      out_duty_a == 16'd0 && out_duty_b == 16'd0 && out_duty_c == 16'd0 && !out_saturated)
    else $error("zero bus item not cleared");

endmodule

bind space_vector_pwm_duties svpd_checker u_svpd_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_sector(out_sector), .out_duty_a(out_duty_a), .out_duty_b(out_duty_b),
  .out_duty_c(out_duty_c), .out_saturated(out_saturated));

>>> tb/sv/tb_space_vector_pwm_duties.sv
module tb_space_vector_pwm_duties;
  import svpd_pkg::*;

  // One expected result item, laid out like the result ports.
  typedef struct {
    logic [2:0]  sector;
    logic [15:0] duty_a, duty_b, duty_c;
    logic [15:0] volt_a, volt_b, volt_c;
    logic        sat;
  } duty_rec_t;

  // One input item.
  typedef struct {
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    logic [15:0]        bus;
  } vec_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_voltage_alpha = '0;
  logic signed [15:0] in_voltage_beta = '0;
  logic [15:0] in_bus_voltage = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_sector;
  logic [15:0] out_duty_a, out_duty_b, out_duty_c;
  logic [15:0] out_phase_volt_a, out_phase_volt_b, out_phase_volt_c;
  logic out_saturated;

  space_vector_pwm_duties dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_voltage_alpha(in_voltage_alpha), .in_voltage_beta(in_voltage_beta),
    .in_bus_voltage(in_bus_voltage),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sector(out_sector),
    .out_duty_a(out_duty_a), .out_duty_b(out_duty_b), .out_duty_c(out_duty_c),
    .out_phase_volt_a(out_phase_volt_a), .out_phase_volt_b(out_phase_volt_b),
    .out_phase_volt_c(out_phase_volt_c),
    .out_saturated(out_saturated)
  );

  always #5 clk = ~clk;

  localparam int DB = DUTY_BITS_DEF;
  localparam int AB = ANGLE_BITS_DEF;

  vec_item_t pending_vecs[$];
  duty_rec_t expected_duties[$];
  int mismatches = 0;
  bit stim_done = 1'b0;
  bit hold_recv = 1'b0;   // forces a long receiver hold-off when set
  bit pause_send = 1'b0;  // the sender waits while this is set

  // Clamps one doubled phase time into 0..den2 and turns it into a rounded
  // duty fraction and a phase voltage; the clamp raises the saturation flag.
  function automatic void phase_duty(input longint twice, input longint den2,
                                     input longint bus, output logic [15:0] duty,
                                     output logic [15:0] volt, inout logic sat);
    longint num;
    longint unsigned q, rem, d, full;
    if (twice < 0) begin
      num = 0;
      sat = 1'b1;
    end else if (twice > den2) begin
      num = den2;
      sat = 1'b1;
    end else begin
      num = twice;
    end
    // Long division gives floor(num * 2^(DB+1) / den2) without overflow.
    q = num / den2;
    rem = num % den2;
    for (int i = 0; i < DB + 1; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den2) begin
        rem = rem - den2;
        q = q | 1;
      end
    end
    d = (q + 1) >> 1;
    full = (64'd1 << DB) - 1;
    if (d > full) d = full;
    duty = d[15:0];
    volt = 16'((d * bus + (64'd1 << (DB - 1))) >> DB);
  endfunction

  // Works out the sector, duties and phase voltages of one vector.
  function automatic duty_rec_t predict_duties(vec_item_t v);
    duty_rec_t r;
    longint a, b, k, one, x2, y2, z2, t1, t2, t0, n, ta, tb, tc, bus;
    logic [2:0] sec;
    bit steep, upper;
    logic s;
    a = v.alpha;
    b = v.beta;
    bus = v.bus;
    r = '{default: '0};
    if (bus == 0) return r;
    if (a == 0) begin
      sec = SEC_2;
    end else begin
      // The sector comes from exact comparisons, so 0 and pi land in 1 and 4.
      steep = (b * b) > (3 * a * a);
      upper = (b > 0) || (b == 0 && a > 0);
      if (upper) sec = steep ? SEC_2 : ((a > 0) ? SEC_1 : SEC_3);
      else sec = steep ? SEC_5 : ((a < 0) ? SEC_4 : SEC_6);
    end
    k = (SQRT3_Q30 + (longint'(1) << (29 - AB))) >>> (30 - AB);
    one = longint'(1) << AB;
    x2 = 2 * k * b;
    y2 = 3 * a * one + k * b;
    z2 = -3 * a * one + k * b;
    case (sec)
      SEC_1: begin t1 = -z2; t2 = x2; end
      SEC_2: begin t1 = y2; t2 = z2; end
      SEC_3: begin t1 = x2; t2 = -y2; end
      SEC_4: begin t1 = z2; t2 = -x2; end
      SEC_5: begin t1 = -y2; t2 = -z2; end
      default: begin t1 = -x2; t2 = y2; end
    endcase
    n = (longint'(1) << (AB + 1)) * bus;
    t0 = n - t1 - t2;
    case (sec)
      SEC_1: begin ta = 2 * (t1 + t2); tb = 2 * t2; tc = 0; end
      SEC_2: begin ta = 2 * t1; tb = 2 * (t1 + t2); tc = 0; end
      SEC_3: begin ta = 0; tb = 2 * (t1 + t2); tc = 2 * t2; end
      SEC_4: begin ta = 0; tb = 2 * t1; tc = 2 * (t1 + t2); end
      SEC_5: begin ta = 2 * t2; tb = 0; tc = 2 * (t1 + t2); end
      default: begin ta = 2 * (t1 + t2); tb = 0; tc = 2 * t1; end
    endcase
    s = 1'b0;
    r.sector = sec;
    phase_duty(ta + t0, 2 * n, bus, r.duty_a, r.volt_a, s);
    phase_duty(tb + t0, 2 * n, bus, r.duty_b, r.volt_b, s);
    phase_duty(tc + t0, 2 * n, bus, r.duty_c, r.volt_c, s);
    r.sat = s;
    return r;
  endfunction

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Driver: presents queued items, keeping a stalled payload unchanged.
  // The expectation is recorded at the edge where the item is accepted.
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_duties.push_back(predict_duties('{in_voltage_alpha,
                                                   in_voltage_beta,
                                                   in_bus_voltage}));
        send_gap = gap_len();
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_vecs.size() > 0 && !pause_send) begin
          in_valid <= 1'b1;
          in_voltage_alpha <= pending_vecs[0].alpha;
          in_voltage_beta <= pending_vecs[0].beta;
          in_bus_voltage <= pending_vecs[0].bus;
          void'(pending_vecs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result item against the oldest expectation
  // and then picks the stall for the next cycle.
  int recv_gap = 0;
  always @(posedge clk) begin
    duty_rec_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_duties.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item, sector %0d", out_sector);
        end else begin
          e = expected_duties.pop_front();
          if (out_sector !== e.sector || out_duty_a !== e.duty_a ||
              out_duty_b !== e.duty_b || out_duty_c !== e.duty_c ||
              out_phase_volt_a !== e.volt_a || out_phase_volt_b !== e.volt_b ||
              out_phase_volt_c !== e.volt_c || out_saturated !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp sec %0d d %0d %0d %0d v %0d %0d %0d s %0d | got sec %0d d %0d %0d %0d v %0d %0d %0d s %0d",
                       e.sector, e.duty_a, e.duty_b, e.duty_c, e.volt_a, e.volt_b,
                       e.volt_c, e.sat, out_sector, out_duty_a, out_duty_b,
                       out_duty_c, out_phase_volt_a, out_phase_volt_b,
                       out_phase_volt_c, out_saturated);
          end
        end
      end
      if (hold_recv) begin
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        out_stall <= 1'b1;
      end else begin
        recv_gap = gap_len();
        out_stall <= (recv_gap > 0);
      end
    end
  end

  task automatic add_vec(int a, int b, int bus);
    pending_vecs.push_back('{16'(a), 16'(b), 16'(bus)});
  endtask

  // Random vector: mostly inside the hexagon for a random bus, with some
  // overmodulation and some raw full-range values.
  task automatic add_random_vec();
    int bus, r, p;
    real ang;
    p = $urandom_range(99);
    if (p < 15) begin
      add_vec($urandom, $urandom, $urandom);
    end else begin
      bus = (p < 20) ? $urandom_range(3, 0) : $urandom_range(65535, 1);
      r = (p < 80) ? $urandom_range(bus * 577 / 1000) : $urandom_range(bus);
      if (r > 32767) r = 32767;
      ang = $urandom_range(62831) / 10000.0;
      add_vec($rtoi(r * $cos(ang)), $rtoi(r * $sin(ang)), bus);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: zero bus, alpha zero with each sign of beta, the exact
    // sector boundaries at 0 and pi, field extremes, full-scale duty and
    // overmodulation.
    add_vec(100, 50, 0);
    add_vec(0, 0, 1000);
    add_vec(0, 500, 1000);
    add_vec(0, -500, 1000);
    add_vec(500, 0, 1000);
    add_vec(-500, 0, 1000);
    add_vec(100, 173, 1000);
    add_vec(100, 174, 1000);
    add_vec(-100, -174, 1000);
    add_vec(100, -173, 1000);
    add_vec(32767, 32767, 65535);
    add_vec(-32768, -32768, 65535);
    add_vec(-32768, 32767, 1);
    add_vec(32767, -32768, 1);
    add_vec(0, -32768, 65535);
    add_vec(0, 32767, 1);
    add_vec(1, 1, 65535);
    add_vec(-1, 0, 1);
    add_vec(20000, 11547, 34641);
    add_vec(30000, 0, 1000);
    add_vec(-30000, 10000, 500);

    for (int i = 0; i < 700; i++) add_random_vec();
    wait (pending_vecs.size() == 0 && expected_duties.size() == 0);

    // Now hold the receiver off for a long stretch while items keep coming,
    // so the queue fills and in_stall rises.
    for (int i = 0; i < 100; i++) add_random_vec();
    hold_recv = 1'b1;
    repeat (200) @(posedge clk);
    hold_recv = 1'b0;

    for (int i = 0; i < 700; i++) add_random_vec();
    wait (pending_vecs.size() == 0 && expected_duties.size() == 0);
    pause_send = 1'b1;
    repeat (DB + 40) @(posedge clk);
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0 && expected_duties.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> filelist.f
src/svpd_pkg.sv
src/svpd_front.sv
src/svpd_fifo.sv
src/svpd_lane.sv
src/svpd_back.sv
src/space_vector_pwm_duties.sv
src/svpd_checker.sv
tb/sv/tb_space_vector_pwm_duties.sv
